// File: sv/fir_filter_sample_defines.svh
// Assertion macros shared by the FIR filter RTL.
// Needs no other file; the including module supplies the clock and reset names.
`ifndef FIR_FILTER_SAMPLE_DEFINES_SVH
`define FIR_FILTER_SAMPLE_DEFINES_SVH

// The condition must hold in the same cycle as its trigger.
`define FS_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after its trigger.
`define FS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: sv/fs_pkg.sv
`timescale 1ns / 1ps
// Package for the FIR filter: sizes, codes, control structs and result types.
// Used by the interfaces and by every module of the block.
package fs_pkg;

    localparam int NUM_TAPS    = 1024;
    localparam int TAP_W       = $clog2(NUM_TAPS);
    localparam int SAMPLE_W    = 32;
    localparam int COEF_W      = 32;
    localparam int IDX_W       = 10;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    // Exact sum of NUM_TAPS products plus headroom for the rounding constant.
    localparam int ACC_W       = PROD_W + TAP_W + 1;
    localparam int SCALE_SHIFT = 28;
    localparam int OUT_TOP     = SCALE_SHIFT + SAMPLE_W - 1;

    localparam logic [TAP_W-1:0]    LAST_TAP   = TAP_W'(NUM_TAPS - 1);
    localparam logic [ACC_W-1:0]    ROUND_HALF = ACC_W'(1) << (SCALE_SHIFT - 1);
    localparam logic [SAMPLE_W-1:0] SAT_MAX    = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAT_MIN    = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Write and read commands from the sequencer to the two memories.
    typedef struct packed {
        logic                coef_we;
        logic [TAP_W-1:0]    coef_waddr;
        logic [COEF_W-1:0]   coef_wdata;
        logic                hist_we;
        logic [TAP_W-1:0]    hist_waddr;
        logic [SAMPLE_W-1:0] hist_wdata;
        logic                rd_en;
        logic                rd_last;
        logic [TAP_W-1:0]    coef_raddr;
        logic [TAP_W-1:0]    hist_raddr;
    } mem_cmd_t;

    // One tap pair as read from the memories.
    typedef struct packed {
        logic                vld;
        logic                last;
        logic [COEF_W-1:0]   coef;
        logic [SAMPLE_W-1:0] sample;
    } tap_rd_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic                saturated;
    } res_t;

endpackage

// File: sv/fs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the FIR filter requests and results.
// Depends on fs_pkg for the field widths.
interface fs_req_if import fs_pkg::*;;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SAMPLE_W-1:0] audio;
    logic [IDX_W-1:0]    coef_index;
    logic [COEF_W-1:0]   coef_value;

    modport source (output valid, req_type, audio, coef_index, coef_value,
                    input ready);
    modport sink   (input valid, req_type, audio, coef_index, coef_value,
                    output ready);
endinterface

interface fs_res_if import fs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] filtered;
    logic                saturated;

    modport source (output valid, filtered, saturated, input ready);
    modport sink   (input valid, filtered, saturated, output ready);
endinterface

// File: sv/fs_store.sv
`timescale 1ns / 1ps
// Coefficient and sample history memories with registered read data.
// Depends on fs_pkg for the command and read data structs.
module fs_store import fs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_cmd_t cmd,
    output tap_rd_t  rd
);

    logic [COEF_W-1:0]   coef_mem [NUM_TAPS];
    logic [SAMPLE_W-1:0] hist_mem [NUM_TAPS];

    logic [COEF_W-1:0]   coef_rd_reg;
    logic [SAMPLE_W-1:0] hist_rd_reg;
    logic                vld_reg;
    logic                last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.coef_we)
        begin
            coef_mem[cmd.coef_waddr] <= cmd.coef_wdata;
        end
        if (cmd.rd_en)
        begin
            coef_rd_reg <= coef_mem[cmd.coef_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_we)
        begin
            hist_mem[cmd.hist_waddr] <= cmd.hist_wdata;
        end
        if (cmd.rd_en)
        begin
            hist_rd_reg <= hist_mem[cmd.hist_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= cmd.rd_en;
            last_reg <= cmd.rd_en & cmd.rd_last;
        end
    end

    assign rd.vld    = vld_reg;
    assign rd.last   = last_reg;
    assign rd.coef   = coef_rd_reg;
    assign rd.sample = hist_rd_reg;

endmodule

// File: sv/fs_mac.sv
`timescale 1ns / 1ps
// Multiply-accumulate datapath with rounding to Q1.31 and saturation.
// Depends on fs_pkg for widths, rounding constant and the result struct.
module fs_mac import fs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  tap_rd_t rd,
    output logic    done,
    output res_t    res
);

    logic signed [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0]        prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_last_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic                     acc_fin_reg;
    logic [ACC_W-1:0]         rnd_reg;
    logic                     neg_reg;
    logic                     rnd_vld_reg;
    logic [ACC_W-OUT_TOP-1:0] upper;
    logic                     fits;
    res_t                     res_next;
    res_t                     res_reg;
    logic                     done_reg;

    assign prod_next = $signed(rd.coef) * $signed(rd.sample);
    assign acc_next  = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // The scaled value fits in 32 bits when every bit above it repeats its sign.
    assign upper = rnd_reg[ACC_W-1:OUT_TOP];
    assign fits  = (&upper) | ~(|upper);

    always_comb
    begin
        res_next.saturated = ~fits;
        if (fits)
        begin
            res_next.filtered = rnd_reg[OUT_TOP:SCALE_SHIFT];
        end
        else if (neg_reg)
        begin
            res_next.filtered = SAT_MIN;
        end
        else
        begin
            res_next.filtered = SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.vld)
        begin
            prod_reg <= prod_next;
        end
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        if (acc_fin_reg)
        begin
            rnd_reg <= acc_reg + ROUND_HALF;
            neg_reg <= acc_reg[ACC_W-1];
        end
        if (rnd_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            acc_fin_reg   <= 1'b0;
            rnd_vld_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            prod_vld_reg  <= rd.vld;
            prod_last_reg <= rd.vld & rd.last;
            acc_fin_reg   <= prod_vld_reg & prod_last_reg;
            rnd_vld_reg   <= acc_fin_reg;
            done_reg      <= rnd_vld_reg;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: sv/fs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: clearing sweep, request intake, the per-tap read walk and the result handoff.
// Depends on fs_pkg and on the request channel interface.
module fs_ctrl import fs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fs_req_if.sink     req,
    input  logic       mac_done,
    input  logic       out_free,
    output logic       out_load,
    output logic       mac_start,
    output mem_cmd_t   cmd,
    output state_t     state
);

    state_t           state_reg;
    state_t           state_next;
    logic [TAP_W-1:0] cnt_reg;
    logic [TAP_W-1:0] cnt_next;
    logic [TAP_W-1:0] hptr_reg;
    logic [TAP_W-1:0] hptr_next;
    logic [TAP_W-1:0] hrd_reg;
    logic [TAP_W-1:0] hrd_next;
    logic             take;
    logic             cnt_last;

    assign take     = (state_reg == ST_IDLE) && req.valid;
    assign cnt_last = (cnt_reg == LAST_TAP);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take && (req.req_type == REQ_SAMPLE))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // The history walk runs backward from the newest sample, wrapping at zero.
    always_comb
    begin
        cnt_next  = '0;
        hptr_next = hptr_reg;
        hrd_next  = hrd_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (take && (req.req_type == REQ_SAMPLE))
                begin
                    hptr_next = (hptr_reg == LAST_TAP) ? '0 : hptr_reg + 1'b1;
                    hrd_next  = hptr_reg;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
                hrd_next = (hrd_reg == '0) ? LAST_TAP : hrd_reg - 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // Writes happen only in the clearing sweep or at intake, reads only during
    // the walk, so the memories never see a read and a write in one cycle.
    always_comb
    begin
        cmd       = '0;
        req.ready = 1'b0;
        mac_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.coef_we    = 1'b1;
                cmd.coef_waddr = cnt_reg;
                cmd.hist_we    = 1'b1;
                cmd.hist_waddr = cnt_reg;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && (req.req_type == REQ_COEF)
                    && (int'(req.coef_index) < NUM_TAPS))
                begin
                    cmd.coef_we    = 1'b1;
                    cmd.coef_waddr = TAP_W'(req.coef_index);
                    cmd.coef_wdata = req.coef_value;
                end
                if (req.valid && (req.req_type == REQ_SAMPLE))
                begin
                    cmd.hist_we    = 1'b1;
                    cmd.hist_waddr = hptr_reg;
                    cmd.hist_wdata = req.audio;
                    mac_start      = 1'b1;
                end
            end
            ST_RUN:
            begin
                cmd.rd_en      = 1'b1;
                cmd.rd_last    = cnt_last;
                cmd.coef_raddr = cnt_reg;
                cmd.hist_raddr = hrd_reg;
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            hptr_reg  <= '0;
            hrd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hptr_reg  <= hptr_next;
            hrd_reg   <= hrd_next;
        end
    end

    assign state = state_reg;

endmodule

// File: sv/fir_filter_sample.sv
`timescale 1ns / 1ps
// Direct-form FIR filter, NUM_TAPS taps, one multiply-accumulate per cycle during the tap walk.
// A sample passes through the tap walk, then the product, accumulator, rounding and result registers;
// the next request is taken, at best, in the same cycle as the earliest result transfer.
// A coefficient write goes into memory at its transfer. The result register lets a new item in.
// After reset a clearing sweep over all NUM_TAPS addresses zeroes both memories first.
`include "fir_filter_sample_defines.svh"

module fir_filter_sample import fs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    fs_req_if.sink  req,
    fs_res_if.source res
);

    mem_cmd_t cmd;
    tap_rd_t  rd;
    state_t   state;
    logic     mac_start;
    logic     mac_done;
    res_t     mac_res;
    logic     out_free;
    logic     out_load;
    logic     out_valid_reg;
    res_t     out_data_reg;
    logic     sample_take;
    logic     walk_busy;
    logic     mem_write;

    assign out_free = ~out_valid_reg | res.ready;

    fs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mac_done  (mac_done),
        .out_free  (out_free),
        .out_load  (out_load),
        .mac_start (mac_start),
        .cmd       (cmd),
        .state     (state)
    );

    fs_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rd    (rd)
    );

    fs_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .rd    (rd),
        .done  (mac_done),
        .res   (mac_res)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= mac_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.filtered  = out_data_reg.filtered;
    assign res.saturated = out_data_reg.saturated;

    assign sample_take = req.valid && req.ready && (req.req_type == REQ_SAMPLE);
    assign walk_busy   = (state == ST_RUN) && cmd.rd_en;
    assign mem_write   = cmd.coef_we | cmd.hist_we;

    `FS_ASSERT_NOW(a_done_in_drain, mac_done, state == ST_DRAIN, "result outside drain")
    `FS_ASSERT_NEXT(a_sample_starts_walk, sample_take, walk_busy, "sample did not start the walk")
    `FS_ASSERT_NOW(a_no_rw_overlap, cmd.rd_en, !mem_write, "memory read and write overlap")
    `FS_ASSERT_NOW(a_load_into_free_slot, out_load, out_free, "result register overwritten")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for fir_filter_sample: directed table, then random traffic.
// Depends on fs_pkg, the fs_req_if/fs_res_if interfaces and the filter RTL.
module testbench import fs_pkg::*;;

    localparam int RANDOM_ITEMS = 560;
    localparam int PAUSE_AT     = 400;
    localparam int HOLD_START   = 150000;
    localparam int HOLD_CYCLES  = 6000;

    typedef enum {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC,
        SINK_SPARSE
    } sink_mode_t;

    typedef struct {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    index;
        logic [COEF_W-1:0]   coef;
        bit                  typed;
        res_t                want;
    } fir_item_t;

    logic clk;
    logic rst_n;

    fs_req_if req();
    fs_res_if res();

    fir_filter_sample u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    // Shadow copy of the filter state.
    logic [SAMPLE_W-1:0] hist_ring [NUM_TAPS];
    logic [COEF_W-1:0]   tap_coef  [NUM_TAPS];
    int                  ring_pos;

    res_t      pending_outputs [$];
    fir_item_t directed_rows   [$];

    int errors;
    int coef_writes;
    int samples_sent;
    int clipped;
    int results_checked;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("testbench failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic fir_item_t make_row(input logic kind, input logic [SAMPLE_W-1:0] sample,
                                           input logic [IDX_W-1:0] index,
                                           input logic [COEF_W-1:0] coef, input bit typed,
                                           input logic [SAMPLE_W-1:0] want_out,
                                           input logic want_sat);
        fir_item_t it;
        it.kind           = kind;
        it.sample         = sample;
        it.index          = index;
        it.coef           = coef;
        it.typed          = typed;
        it.want.filtered  = want_out;
        it.want.saturated = want_sat;
        return it;
    endfunction

    // Exact direct-form sum, round half up at bit 27, then clip to 32 bits.
    function automatic res_t run_filter(input logic [SAMPLE_W-1:0] x);
        logic signed [127:0] sum;
        logic signed [127:0] scaled;
        logic signed [63:0]  prod;
        int                  j;
        res_t                y;
        hist_ring[ring_pos] = x;
        sum = '0;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            j    = (ring_pos + NUM_TAPS - k) % NUM_TAPS;
            prod = $signed(tap_coef[k]) * $signed(hist_ring[j]);
            sum  = sum + prod;
        end
        ring_pos = (ring_pos + 1) % NUM_TAPS;
        scaled = (sum + (128'sd1 <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
        if ((&scaled[127:SAMPLE_W-1]) || !(|scaled[127:SAMPLE_W-1]))
        begin
            y.filtered  = scaled[SAMPLE_W-1:0];
            y.saturated = 1'b0;
        end
        else
        begin
            // The sign of the exact sum picks the rail.
            y.filtered  = sum[127] ? SAT_MIN : SAT_MAX;
            y.saturated = 1'b1;
        end
        return y;
    endfunction

    task automatic record_transfer(input fir_item_t it);
        res_t y;
        if (it.kind == REQ_COEF)
        begin
            if (int'(it.index) < NUM_TAPS)
                tap_coef[it.index] = it.coef;
            coef_writes++;
        end
        else
        begin
            y = run_filter(it.sample);
            if (it.typed)
                y = it.want;
            pending_outputs.push_back(y);
            samples_sent++;
            if (y.saturated)
                clipped++;
        end
    endtask

    task automatic send_item(input fir_item_t it);
        req.valid      <= 1'b1;
        req.req_type   <= it.kind;
        req.audio      <= it.sample;
        req.coef_index <= it.index;
        req.coef_value <= it.coef;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        record_transfer(it);
    endtask

    // Drop valid and put noise on the payload while the sender is quiet.
    task automatic idle_sender(input int cycles);
        req.valid      <= 1'b0;
        req.req_type   <= 1'($urandom);
        req.audio      <= SAMPLE_W'($urandom);
        req.coef_index <= IDX_W'($urandom);
        req.coef_value <= COEF_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Receiver: changing stall patterns, plus one long hold-off that fills the block.
    initial
    begin
        int unsigned cyc;
        sink_mode_t  mode;
        int          mode_left;
        res.ready <= 1'b0;
        cyc       = 0;
        mode      = SINK_OPEN;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
                res.ready <= 1'b0;
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(1, 300);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:     res.ready <= 1'b1;
                    SINK_RANDOM:   res.ready <= ($urandom_range(0, 3) != 0);
                    SINK_PERIODIC: res.ready <= (cyc % 5 != 0);
                    default:       res.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_outputs.size() == 0)
                report_mismatch($sformatf("result %h/%b with none expected",
                                          res.filtered, res.saturated));
            else
            begin
                want = pending_outputs.pop_front();
                results_checked++;
                if (res.filtered !== want.filtered || res.saturated !== want.saturated)
                    report_mismatch($sformatf("result %0d: filtered %h want %h, saturated %b want %b",
                                              results_checked, res.filtered, want.filtered,
                                              res.saturated, want.saturated));
            end
        end
    end

    initial
    begin
        fir_item_t           it;
        logic [31:0]         raw;
        logic [COEF_W-1:0]   cv;
        logic [IDX_W-1:0]    idx;
        int                  burst_left;

        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.req_type   <= REQ_COEF;
        req.audio      <= '0;
        req.coef_index <= '0;
        req.coef_value <= '0;
        errors          = 0;
        coef_writes     = 0;
        samples_sent    = 0;
        clipped         = 0;
        results_checked = 0;
        ring_pos        = 0;
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            hist_ring[i] = '0;
            tap_coef[i]  = '0;
        end

        // Only tap 0 is nonzero until late in the table, so the typed rows
        // depend on the current sample alone.
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h1234_5678, 10'h3FF, 32'hFFFF_FFFF,
                                         1, 32'h0000_0000, 1'b0));
        directed_rows.push_back(make_row(REQ_COEF, 32'hFFFF_FFFF, 10'h000, 32'h1000_0000,
                                         0, '0, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h7FFF_FFFF, 10'h000, 32'h0000_0000,
                                         1, 32'h7FFF_FFFF, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h8000_0000, 10'h000, 32'h0000_0000,
                                         1, 32'h8000_0000, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h0000_0000, 10'h000, 32'h0000_0000,
                                         1, 32'h0000_0000, 1'b0));
        directed_rows.push_back(make_row(REQ_COEF, 32'h0000_0000, 10'h000, 32'h7FFF_FFFF,
                                         0, '0, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h7FFF_FFFF, 10'h000, 32'h0000_0000,
                                         1, SAT_MAX, 1'b1));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h8000_0000, 10'h000, 32'h0000_0000,
                                         1, SAT_MIN, 1'b1));
        directed_rows.push_back(make_row(REQ_COEF, 32'h0000_0000, 10'h000, 32'h8000_0000,
                                         0, '0, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h8000_0000, 10'h000, 32'h0000_0000,
                                         1, SAT_MAX, 1'b1));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h7FFF_FFFF, 10'h000, 32'h0000_0000,
                                         1, SAT_MIN, 1'b1));
        directed_rows.push_back(make_row(REQ_COEF, 32'h0000_0000, 10'h000, 32'h0000_0001,
                                         0, '0, 1'b0));
        // Exact half rounds up, toward positive infinity on both signs.
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h0800_0000, 10'h000, 32'h0000_0000,
                                         1, 32'h0000_0001, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'hF800_0000, 10'h000, 32'h0000_0000,
                                         1, 32'h0000_0000, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'hF7FF_FFFF, 10'h000, 32'h0000_0000,
                                         1, 32'hFFFF_FFFF, 1'b0));
        directed_rows.push_back(make_row(REQ_COEF, 32'h0000_0000, 10'h3FF, 32'h1000_0000,
                                         0, '0, 1'b0));
        directed_rows.push_back(make_row(REQ_COEF, 32'h0000_0000, 10'h000, 32'hF000_0000,
                                         0, '0, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h4000_0000, 10'h2AA, 32'h5555_5555,
                                         0, '0, 1'b0));
        directed_rows.push_back(make_row(REQ_COEF, 32'hA5A5_A5A5, 10'h200, 32'h5A5A_5A5A,
                                         0, '0, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'hA5A5_A5A5, 10'h155, 32'hAAAA_AAAA,
                                         0, '0, 1'b0));
        directed_rows.push_back(make_row(REQ_COEF, 32'h0000_0000, 10'h001, 32'h1000_0000,
                                         0, '0, 1'b0));
        directed_rows.push_back(make_row(REQ_SAMPLE, 32'h5555_5555, 10'h000, 32'h0000_0000,
                                         0, '0, 1'b0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i]);
            if ($urandom_range(0, 1) != 0)
                idle_sender($urandom_range(1, 4));
        end

        // Magnitudes are spread by random shifts, and most writes hit a few low
        // taps, so results land both inside the range and on the rails.
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == PAUSE_AT)
            begin
                idle_sender(1);
                while (pending_outputs.size() != 0)
                    @(posedge clk);
            end
            raw = $urandom;
            cv  = COEF_W'($signed(raw) >>> $urandom_range(0, 31));
            if ($urandom_range(0, 4) == 0)
                cv = '0;
            if ($urandom_range(0, 3) != 0)
                idx = IDX_W'($urandom_range(0, 15));
            else
                idx = IDX_W'($urandom);
            raw = $urandom;
            it = make_row(($urandom_range(0, 99) < 35) ? REQ_COEF : REQ_SAMPLE,
                          SAMPLE_W'($signed(raw) >>> $urandom_range(0, 31)),
                          idx, cv, 0, '0, 1'b0);
            send_item(it);
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 12));
            end
            else
                burst_left--;
        end
        idle_sender(1);

        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (NUM_TAPS + 32) @(posedge clk);

        $display("Covered %0d coefficient writes and %0d samples; %0d results clipped.",
                 coef_writes, samples_sent, clipped);
        $display("%0d results checked in order, %0d mismatches.", results_checked, errors);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: fir_filter_sample.f
+incdir+sv
sv/fs_pkg.sv
sv/fs_if.sv
sv/fs_store.sv
sv/fs_mac.sv
sv/fs_ctrl.sv
sv/fir_filter_sample.sv
sim/testbench.sv
